[rtl/core/pds_pkg.sv]
`default_nettype none
// pds_pkg: types and constants shared by the pll divider search unit
// no dependencies

package pds_pkg;

  localparam int unsigned TARGET_W    = 18;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned PROD_W      = 7;
  localparam int unsigned X_W         = TARGET_W + PROD_W;
  localparam int unsigned T_W         = X_W + 1;
  localparam int unsigned FB_W        = 8;
  localparam int unsigned U_W         = 13;
  localparam int unsigned RECIP_SH    = 17;

  localparam int unsigned REF_MHZ     = 25;
  localparam int unsigned FB_MIN      = 144;
  localparam int unsigned FB_MAX      = 235;
  localparam int unsigned MAX_DIFF    = 10;
  localparam int unsigned VCO_LIMIT   = 2400;

  localparam logic [T_W-1:0] HALF_DEN = T_W'(REF_MHZ << (FRAC_BITS - 1));
  localparam logic [T_W-1:0] T_LOW    = T_W'(FB_MIN * (REF_MHZ << FRAC_BITS));
  localparam logic [T_W-1:0] T_HIGH   = T_W'((FB_MAX + 1) * (REF_MHZ << FRAC_BITS));
  // ceil(2^17 / 25), exact floor division for quotients below 2^13
  localparam logic [U_W-1:0] RECIP_25 = U_W'(((1 << RECIP_SH) + REF_MHZ - 1) / REF_MHZ);

  localparam logic [7:0] VCO_HIGH     = 8'h50;
  localparam logic [7:0] VCO_LOW      = 8'h40;
  localparam logic [7:0] DEFAULT_FB   = 8'hA0;
  localparam logic [7:0] DEFAULT_REF  = 8'h02;
  localparam logic [7:0] DEFAULT_POST = 8'h41;

  localparam logic [1:0] REF_FIRST    = 2'd2;
  localparam logic [1:0] REF_LAST     = 2'd1;
  localparam logic [2:0] PD1_FIRST    = 3'd7;
  localparam logic [2:0] PD1_LAST     = 3'd2;
  localparam logic [2:0] PD2_FIRST    = 3'd1;

  typedef enum logic [1:0] {
    PDS_IDLE,
    PDS_MUL,
    PDS_CHK,
    PDS_DONE
  } pds_state_e;

  typedef struct packed {
    logic [1:0] ref_div;
    logic [2:0] pd1;
    logic [2:0] pd2;
  } pds_cand_t;

  typedef struct packed {
    logic      ld_x;
    pds_cand_t cand;
  } pds_ctl_t;

  typedef struct packed {
    logic            hit;
    logic            vco_hi;
    logic [FB_W-1:0] fb;
  } pds_eval_t;

endpackage

`default_nettype wire

[rtl/core/pds_eval.sv]
`default_nettype none
// pds_eval: shared arithmetic unit, scales the target by the divider product,
// rounds the feedback divider, tests range, distance and vco; uses pds_pkg

module pds_eval import pds_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic [TARGET_W-1:0] target_i,
  input  wire pds_ctl_t            ctl_i,
  output pds_eval_t                eval_o
);

  logic [PROD_W-1:0]   prod;
  logic [X_W-1:0]      x_d;
  logic [X_W-1:0]      x_q;
  logic [T_W-1:0]      t_sum;
  logic                in_range;
  logic [U_W-1:0]      u_val;
  logic [2*U_W-1:0]    recip_prod;
  logic [FB_W-1:0]     fb;
  logic [T_W-1:0]      f_scaled;
  logic [T_W-1:0]      diff;
  logic [T_W-1:0]      limit;
  logic [U_W:0]        fb_mhz;
  logic [U_W:0]        vco_bound;

  assign prod = PROD_W'(ctl_i.cand.ref_div) * PROD_W'(ctl_i.cand.pd1)
              * PROD_W'(ctl_i.cand.pd2);

  assign x_d = X_W'(target_i) * X_W'(prod);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_x) begin
      x_q <= x_d;
    end
  end

  // rounding half away from zero: fb = floor((x + den/2) / den)
  assign t_sum      = T_W'(x_q) + HALF_DEN;
  assign in_range   = (t_sum >= T_LOW) && (t_sum < T_HIGH);
  assign u_val      = t_sum[FRAC_BITS +: U_W];
  assign recip_prod = (2*U_W)'(u_val) * (2*U_W)'(RECIP_25);
  assign fb         = recip_prod[RECIP_SH +: FB_W];

  assign f_scaled = T_W'((T_W'(fb) << 4) + (T_W'(fb) << 3) + T_W'(fb)) << FRAC_BITS;
  assign diff     = (T_W'(x_q) >= f_scaled) ? (T_W'(x_q) - f_scaled)
                                            : (f_scaled - T_W'(x_q));
  assign limit    = T_W'(T_W'(prod) * T_W'(MAX_DIFF)) << FRAC_BITS;

  assign fb_mhz    = (U_W+1)'(fb) * (U_W+1)'(REF_MHZ);
  assign vco_bound = (U_W+1)'(ctl_i.cand.ref_div) * (U_W+1)'(VCO_LIMIT);

  assign eval_o.hit    = in_range && (diff < limit);
  assign eval_o.vco_hi = (fb_mhz >= vco_bound);
  assign eval_o.fb     = fb;

endmodule

`default_nettype wire

[rtl/core/pds_seq.sv]
`default_nettype none
// pds_seq: sequencer that walks the divider sets in search order and holds
// the result word; uses pds_pkg, drives pds_eval

module pds_seq import pds_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire pds_eval_t eval_i,
  output pds_ctl_t       ctl_o,
  output logic           busy_o,
  output logic           done_o,
  output logic           found_o,
  output logic [7:0]     vco_select_byte_o,
  output logic [7:0]     feedback_divider_o,
  output logic [7:0]     reference_divider_o,
  output logic [7:0]     post_divider_byte_o
);

  pds_state_e state_q;
  pds_state_e state_d;
  pds_cand_t  cand_q;
  pds_cand_t  cand_d;
  pds_cand_t  cand_next;
  logic       last_cand;
  logic       found_q;
  logic [7:0] vco_q;
  logic [7:0] fb_q;
  logic [7:0] ref_q;
  logic [7:0] post_q;

  assign last_cand = (cand_q.ref_div == REF_LAST) && (cand_q.pd1 == PD1_LAST);

  always_comb begin
    cand_next = cand_q;
    if (cand_q.pd2 + 3'd1 < cand_q.pd1) begin
      cand_next.pd2 = cand_q.pd2 + 3'd1;
    end else if (cand_q.pd1 > PD1_LAST) begin
      cand_next.pd1 = cand_q.pd1 - 3'd1;
      cand_next.pd2 = PD2_FIRST;
    end else begin
      cand_next.ref_div = REF_LAST;
      cand_next.pd1     = PD1_FIRST;
      cand_next.pd2     = PD2_FIRST;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cand_d  = cand_q;
    unique case (state_q)
      PDS_IDLE: begin
        if (start_i) begin
          state_d = PDS_MUL;
          cand_d  = '{ref_div: REF_FIRST, pd1: PD1_FIRST, pd2: PD2_FIRST};
        end
      end
      PDS_MUL: begin
        state_d = PDS_CHK;
      end
      PDS_CHK: begin
        if (eval_i.hit || last_cand) begin
          state_d = PDS_DONE;
        end else begin
          state_d = PDS_MUL;
          cand_d  = cand_next;
        end
      end
      PDS_DONE: begin
        state_d = PDS_IDLE;
      end
      default: begin
        state_d = PDS_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctl_o.cand = cand_q;
    ctl_o.ld_x = 1'b0;
    busy_o     = 1'b1;
    done_o     = 1'b0;
    unique case (state_q)
      PDS_IDLE: busy_o     = 1'b0;
      PDS_MUL:  ctl_o.ld_x = 1'b1;
      PDS_CHK:  ;
      PDS_DONE: done_o     = 1'b1;
      default:  busy_o     = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PDS_IDLE;
      cand_q  <= '{ref_div: REF_FIRST, pd1: PD1_FIRST, pd2: PD2_FIRST};
    end else begin
      state_q <= state_d;
      cand_q  <= cand_d;
    end
  end

  // result word, defaults when the last set misses
  always_ff @(posedge clk_i) begin
    if (state_q == PDS_CHK) begin
      if (eval_i.hit) begin
        found_q <= 1'b1;
        vco_q   <= eval_i.vco_hi ? VCO_HIGH : VCO_LOW;
        fb_q    <= eval_i.fb;
        ref_q   <= {6'd0, cand_q.ref_div};
        post_q  <= {1'b0, cand_q.pd1 - 3'd1, 1'b0, cand_q.pd2 - 3'd1};
      end else if (last_cand) begin
        found_q <= 1'b0;
        vco_q   <= VCO_LOW;
        fb_q    <= DEFAULT_FB;
        ref_q   <= DEFAULT_REF;
        post_q  <= DEFAULT_POST;
      end
    end
  end

  assign found_o             = found_q;
  assign vco_select_byte_o   = vco_q;
  assign feedback_divider_o  = fb_q;
  assign reference_divider_o = ref_q;
  assign post_divider_byte_o = post_q;

endmodule

`default_nettype wire

[rtl/core/pll_divider_search_unit.sv]
`default_nettype none
// pll_divider_search_unit: top level of the pll divider search
// uses pds_pkg, pds_seq and pds_eval
//
// channel   dir  ports                                   handshake
// command   in   target_q8_i                             start_i, busy_o
// result    out  found_o, vco_select_byte_o,              done_o, one cycle
//                feedback_divider_o, reference_divider_o,
//                post_divider_byte_o
//
// each divider set goes through the shared multiplier and compare unit: PDS_MUL
// scales the target, PDS_CHK rounds and tests; up to 42 sets are tried
// done_o rises after PDS_CHK of the first set that hits, or of the last set
// the next word can be taken once busy_o is low again, back in PDS_IDLE
// busy_o is high from the cycle after accept up to and including the done_o cycle
// result holds past done_o until the next search ends; the receiver cannot stall
// reset clears the sequencer; result registers carry no reset

module pll_divider_search_unit import pds_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [TARGET_W-1:0] target_q8_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic                     found_o,
  output logic [7:0]               vco_select_byte_o,
  output logic [7:0]               feedback_divider_o,
  output logic [7:0]               reference_divider_o,
  output logic [7:0]               post_divider_byte_o
);

  logic [TARGET_W-1:0] target_q;
  pds_ctl_t            ctl;
  pds_eval_t           eval;

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      target_q <= target_q8_i;
    end
  end

  pds_seq u_seq (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .eval_i              (eval),
    .ctl_o               (ctl),
    .busy_o              (busy_o),
    .done_o              (done_o),
    .found_o             (found_o),
    .vco_select_byte_o   (vco_select_byte_o),
    .feedback_divider_o  (feedback_divider_o),
    .reference_divider_o (reference_divider_o),
    .post_divider_byte_o (post_divider_byte_o)
  );

  pds_eval u_eval (
    .clk_i    (clk_i),
    .target_i (target_q),
    .ctl_i    (ctl),
    .eval_o   (eval)
  );

`ifndef SYNTHESIS
  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("done_o outside a search");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("search did not start after accept");

  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> ((feedback_divider_o >= 8'(FB_MIN)) &&
                             (feedback_divider_o <= 8'(FB_MAX))))
    else $error("feedback divider out of range");

  a_default_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> ((feedback_divider_o == DEFAULT_FB) &&
                              (post_divider_byte_o == DEFAULT_POST)))
    else $error("default word wrong");
`endif

endmodule

`default_nettype wire
